// File: rtl/http_chunked_body_decoder_core_macros.svh
// assertion macros for the checker file
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HCBD_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("hcbd check failed");

// next-cycle implication, disabled while in reset
`define HCBD_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("hcbd check failed");

`endif

// File: rtl/hcbd_pkg.sv
// types, constants and codes of the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int LEN_BITS   = 32;
    localparam int COUNT_BITS = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    typedef enum logic [7:0] {
        PH_LEAD   = 8'b0000_0001,
        PH_SIGN   = 8'b0000_0010,
        PH_ZERO   = 8'b0000_0100,
        PH_PREFIX = 8'b0000_1000,
        PH_DIGITS = 8'b0001_0000,
        PH_LINE   = 8'b0010_0000,
        PH_DATA   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [LEN_BITS-1:0]     size_accum;
        logic [LEN_BITS-1:0]     bytes_left;
        logic [COUNT_BITS-1:0]   out_count;
    } state_t;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    is_data;
        logic                    end_of_body;
        logic [COUNT_BITS-1:0]   decoded_length;
    } res_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_LEAD,
        size_accum: '0,
        bytes_left: '0,
        out_count:  '0
    };

endpackage

// File: rtl/hcbd_parse.sv
// per-byte parse logic: next state and up to two result records
`timescale 1ns / 1ps

module hcbd_parse (
    input  logic [7:0]       in_byte,
    input  logic             last_byte,
    input  hcbd_pkg::state_t cur,
    output hcbd_pkg::state_t nxt,
    output hcbd_pkg::res_t   res0,
    output hcbd_pkg::res_t   res1,
    output logic [1:0]       push_n
);

    logic       hex_ok;
    logic [3:0] hex_d;
    logic       is_space;
    logic       is_crlf;
    logic       data;
    logic [hcbd_pkg::COUNT_BITS-1:0] count_final;

    function automatic logic [hcbd_pkg::LEN_BITS-1:0] add_digit(
        input logic [hcbd_pkg::LEN_BITS-1:0] acc,
        input logic [3:0]                    d
    );
        logic [hcbd_pkg::LEN_BITS-1:0] r;
        if (|acc[hcbd_pkg::LEN_BITS-1 -: 4]) begin
            r = '1;
        end else begin
            r = {acc[hcbd_pkg::LEN_BITS-5:0], d};
        end
        return r;
    endfunction

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (in_byte >= hcbd_pkg::CH_ZERO && in_byte <= hcbd_pkg::CH_NINE) begin
            hex_d = in_byte[3:0];
        end else if (in_byte >= hcbd_pkg::CH_LA && in_byte <= hcbd_pkg::CH_LF_HEX) begin
            hex_d = 4'(in_byte - hcbd_pkg::CH_LA) + hcbd_pkg::HEX_TEN;
        end else if (in_byte >= hcbd_pkg::CH_UA && in_byte <= hcbd_pkg::CH_UF) begin
            hex_d = 4'(in_byte - hcbd_pkg::CH_UA) + hcbd_pkg::HEX_TEN;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_space = (in_byte == hcbd_pkg::CH_SPACE) ||
                      (in_byte >= hcbd_pkg::CH_TAB && in_byte <= hcbd_pkg::CH_CR);
    assign is_crlf  = (in_byte == hcbd_pkg::CH_CR) || (in_byte == hcbd_pkg::CH_LF);

    always_comb begin
        nxt         = cur;
        data        = 1'b0;
        count_final = '0;
        unique case (cur.phase)
            hcbd_pkg::PH_LEAD: begin
                if (!is_space) begin
                    nxt.size_accum = '0;
                    if (in_byte == hcbd_pkg::CH_PLUS) begin
                        nxt.phase = hcbd_pkg::PH_SIGN;
                    end else if (in_byte == hcbd_pkg::CH_ZERO) begin
                        nxt.phase = hcbd_pkg::PH_ZERO;
                    end else if (hex_ok) begin
                        nxt.size_accum = add_digit('0, hex_d);
                        nxt.phase      = hcbd_pkg::PH_DIGITS;
                    end else begin
                        nxt.phase = hcbd_pkg::PH_DONE;
                    end
                end
            end
            hcbd_pkg::PH_SIGN: begin
                if (in_byte == hcbd_pkg::CH_ZERO) begin
                    nxt.phase = hcbd_pkg::PH_ZERO;
                end else if (hex_ok) begin
                    nxt.size_accum = add_digit(cur.size_accum, hex_d);
                    nxt.phase      = hcbd_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_ZERO: begin
                if (in_byte == hcbd_pkg::CH_LX || in_byte == hcbd_pkg::CH_UX) begin
                    nxt.phase = hcbd_pkg::PH_PREFIX;
                end else if (hex_ok) begin
                    nxt.size_accum = add_digit(cur.size_accum, hex_d);
                    nxt.phase      = hcbd_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_PREFIX: begin
                if (hex_ok) begin
                    nxt.size_accum = add_digit(cur.size_accum, hex_d);
                    nxt.phase      = hcbd_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_DIGITS: begin
                if (hex_ok) begin
                    nxt.size_accum = add_digit(cur.size_accum, hex_d);
                end else if (cur.size_accum == '0) begin
                    nxt.phase = hcbd_pkg::PH_DONE;
                end else begin
                    nxt.bytes_left = cur.size_accum;
                    nxt.size_accum = '0;
                    if (is_crlf) begin
                        nxt.phase = hcbd_pkg::PH_LINE;
                    end else begin
                        data = 1'b1;
                    end
                end
            end
            hcbd_pkg::PH_LINE: begin
                if (!is_crlf) begin
                    data = 1'b1;
                end
            end
            hcbd_pkg::PH_DATA: begin
                data = 1'b1;
            end
            hcbd_pkg::PH_DONE: begin
                nxt.phase = hcbd_pkg::PH_DONE;
            end
            default: begin
                nxt.phase = hcbd_pkg::PH_DONE;
            end
        endcase

        if (data) begin
            if (cur.out_count != '1) begin
                nxt.out_count = cur.out_count + 1'b1;
            end
            nxt.bytes_left = nxt.bytes_left -
                {{(hcbd_pkg::LEN_BITS-1){1'b0}}, (|nxt.bytes_left)};
            nxt.phase = (nxt.bytes_left == '0) ? hcbd_pkg::PH_LEAD : hcbd_pkg::PH_DATA;
        end

        count_final = nxt.out_count;
        if (last_byte) begin
            nxt = hcbd_pkg::STATE_RESET;
        end
    end

    always_comb begin
        hcbd_pkg::res_t data_rec;
        hcbd_pkg::res_t end_rec;
        data_rec = '{out_byte: in_byte, is_data: 1'b1, end_of_body: 1'b0,
                     decoded_length: '0};
        end_rec  = '{out_byte: 8'd0, is_data: 1'b0, end_of_body: 1'b1,
                     decoded_length: count_final};
        res0   = data ? data_rec : end_rec;
        res1   = end_rec;
        push_n = {1'b0, data} + {1'b0, last_byte};
    end

endmodule

// File: rtl/hcbd_fifo.sv
// small result queue, two writes and one read a cycle
`timescale 1ns / 1ps

module hcbd_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                push_n,
    input  hcbd_pkg::res_t            wr0,
    input  hcbd_pkg::res_t            wr1,
    input  logic                      pop,
    output hcbd_pkg::res_t            rd,
    output logic [hcbd_pkg::CNT_W-1:0] count
);

    hcbd_pkg::res_t                  entry_reg [hcbd_pkg::FIFO_DEPTH];
    logic [hcbd_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hcbd_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hcbd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [hcbd_pkg::PTR_W-1:0]      wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + push_n[hcbd_pkg::PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + {{(hcbd_pkg::PTR_W-1){1'b0}}, pop};
    assign count_next  = count_reg + hcbd_pkg::CNT_W'(push_n)
                         - {{(hcbd_pkg::CNT_W-1){1'b0}}, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr0;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_inc] <= wr1;
        end
    end

    assign rd    = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/http_chunked_body_decoder_core.sv
// top level of the chunked transfer body decoder
//
// body bytes enter on the s_ stream, one byte per beat, s_tlast on the final
// byte of a body. decoded data bytes leave on the m_ stream with m_tuser high;
// an end record (m_tuser low, m_tlast high, decoded length in m_tdata[39:8])
// follows the final byte of each body.
// each accepted byte is parsed in the cycle it is taken and its results are
// written to a four-entry queue; m_ shows the registered head of that queue.
// throughput is one byte per cycle while s_tready is high; a final byte that
// carries data gives two output beats, the queue drains at one beat per cycle
// while m_tready is high, and s_tready drops while three or more results wait.
// a stall on m_ holds the head result; bytes keep being accepted until the
// queue is nearly full.
// reset empties the queue and returns the parser to the size line lead;
// state also returns there after every end record.
`timescale 1ns / 1ps

module http_chunked_body_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte[7:0], decoded_length[39:8]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast
);

    hcbd_pkg::state_t               st_reg, st_next, st_parsed;
    hcbd_pkg::res_t                 res0, res1, head;
    logic [1:0]                     parse_n;
    logic [1:0]                     push_n;
    logic [hcbd_pkg::CNT_W-1:0]     count;
    logic                           accept;
    logic                           pop;

    assign s_tready = count < hcbd_pkg::CNT_W'(hcbd_pkg::FIFO_DEPTH - 1);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = count != '0;
    assign pop      = m_tvalid && m_tready;

    hcbd_parse u_parse (
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .cur       (st_reg),
        .nxt       (st_parsed),
        .res0      (res0),
        .res1      (res1),
        .push_n    (parse_n)
    );

    assign st_next = accept ? st_parsed : st_reg;
    assign push_n  = accept ? parse_n : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= hcbd_pkg::STATE_RESET;
        end else begin
            st_reg <= st_next;
        end
    end

    hcbd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .wr0     (res0),
        .wr1     (res1),
        .pop     (pop),
        .rd      (head),
        .count   (count)
    );

    assign m_tdata = {head.decoded_length, head.out_byte};
    assign m_tuser = head.is_data;
    assign m_tlast = head.end_of_body;

endmodule

// File: rtl/hcbd_checker.sv
// port-level checks of the chunked body decoder, bound to the top level
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic        s_fire;
    logic [41:0] m_beat;
    assign s_fire = s_tvalid && s_tready;
    assign m_beat = {m_tdata, m_tuser, m_tlast};

    `HCBD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_beat))
    `HCBD_ASSERT_IMP(a_end_rec, aclk, aresetn, m_tvalid && m_tlast, !m_tuser && (m_tdata[7:0] == 8'd0))
    `HCBD_ASSERT_IMP(a_data_rec, aclk, aresetn, m_tvalid && m_tuser, !m_tlast && (m_tdata[39:8] == 32'd0))
    `HCBD_ASSERT_NEXT(a_end_queued, aclk, aresetn, s_fire && s_tlast, m_tvalid)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/tb_top.sv
// testbench for the chunked body decoder: random bodies, byte predictor, stream checker
`timescale 1ns / 1ps

module tb_top;

    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam int RAND_ITEMS = 1450;
    localparam int HOLD_A     = 600;
    localparam int HOLD_B     = 2500;
    localparam int HOLD_LEN   = 250;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    byte_beat_t       byte_q[$];
    logic [7:0]       body_buf[$];
    hcbd_pkg::res_t   result_q[$];
    int               errors = 0;
    int               n_directed;

    // decoder state as the predictor sees it
    hcbd_pkg::phase_t                dec_phase = hcbd_pkg::PH_LEAD;
    logic [hcbd_pkg::LEN_BITS-1:0]   dec_size  = '0;
    logic [hcbd_pkg::LEN_BITS-1:0]   dec_left  = '0;
    logic [hcbd_pkg::COUNT_BITS-1:0] dec_count = '0;

    http_chunked_body_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int hex_val(logic [7:0] c);
        if (c >= hcbd_pkg::CH_ZERO && c <= hcbd_pkg::CH_NINE) return int'(c - hcbd_pkg::CH_ZERO);
        if (c >= hcbd_pkg::CH_LA && c <= hcbd_pkg::CH_LF_HEX) return int'(c - hcbd_pkg::CH_LA) + 10;
        if (c >= hcbd_pkg::CH_UA && c <= hcbd_pkg::CH_UF) return int'(c - hcbd_pkg::CH_UA) + 10;
        return -1;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == hcbd_pkg::CH_SPACE || (c >= hcbd_pkg::CH_TAB && c <= hcbd_pkg::CH_CR);
    endfunction

    function automatic void push_digit(int d);
        logic [hcbd_pkg::LEN_BITS+4:0] wide;
        wide = {1'b0, dec_size, 4'b0000} + (hcbd_pkg::LEN_BITS+5)'(d);
        if (wide[hcbd_pkg::LEN_BITS+4:hcbd_pkg::LEN_BITS] != '0) begin
            dec_size = '1;
        end else begin
            dec_size = wide[hcbd_pkg::LEN_BITS-1:0];
        end
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic last);
        int             h;
        bit             emit;
        hcbd_pkg::res_t r;
        h = hex_val(c);
        emit = 1'b0;
        case (dec_phase)
            hcbd_pkg::PH_LEAD: begin
                if (!is_ws(c)) begin
                    dec_size = '0;
                    if (c == hcbd_pkg::CH_PLUS) dec_phase = hcbd_pkg::PH_SIGN;
                    else if (c == hcbd_pkg::CH_ZERO) dec_phase = hcbd_pkg::PH_ZERO;
                    else if (h >= 0) begin
                        push_digit(h);
                        dec_phase = hcbd_pkg::PH_DIGITS;
                    end else dec_phase = hcbd_pkg::PH_DONE;
                end
            end
            hcbd_pkg::PH_SIGN: begin
                if (c == hcbd_pkg::CH_ZERO) dec_phase = hcbd_pkg::PH_ZERO;
                else if (h >= 0) begin
                    push_digit(h);
                    dec_phase = hcbd_pkg::PH_DIGITS;
                end else dec_phase = hcbd_pkg::PH_DONE;
            end
            hcbd_pkg::PH_ZERO: begin
                if (c == hcbd_pkg::CH_LX || c == hcbd_pkg::CH_UX) begin
                    dec_phase = hcbd_pkg::PH_PREFIX;
                end else if (h >= 0) begin
                    push_digit(h);
                    dec_phase = hcbd_pkg::PH_DIGITS;
                end else dec_phase = hcbd_pkg::PH_DONE;
            end
            hcbd_pkg::PH_PREFIX: begin
                if (h >= 0) begin
                    push_digit(h);
                    dec_phase = hcbd_pkg::PH_DIGITS;
                end else dec_phase = hcbd_pkg::PH_DONE;
            end
            hcbd_pkg::PH_DIGITS: begin
                if (h >= 0) push_digit(h);
                else if (dec_size == '0) dec_phase = hcbd_pkg::PH_DONE;
                else begin
                    dec_left = dec_size;
                    dec_size = '0;
                    if (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_LF) begin
                        dec_phase = hcbd_pkg::PH_LINE;
                    end else emit = 1'b1;
                end
            end
            hcbd_pkg::PH_LINE: begin
                if (c != hcbd_pkg::CH_CR && c != hcbd_pkg::CH_LF) emit = 1'b1;
            end
            hcbd_pkg::PH_DATA: begin
                emit = 1'b1;
            end
            default: begin
                dec_phase = hcbd_pkg::PH_DONE;
            end
        endcase
        if (emit) begin
            r = '{out_byte: c, is_data: 1'b1, end_of_body: 1'b0, decoded_length: '0};
            result_q.push_back(r);
            if (dec_count != '1) dec_count = dec_count + 1'b1;
            if (dec_left != '0) dec_left = dec_left - 1'b1;
            dec_phase = (dec_left == '0) ? hcbd_pkg::PH_LEAD : hcbd_pkg::PH_DATA;
        end
        if (last) begin
            r = '{out_byte: 8'h00, is_data: 1'b0, end_of_body: 1'b1,
                  decoded_length: dec_count};
            result_q.push_back(r);
            dec_phase = hcbd_pkg::PH_LEAD;
            dec_size  = '0;
            dec_left  = '0;
            dec_count = '0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stimulus building
    function automatic logic [7:0] hex_char(int d);
        if (d < 10) return 8'(hcbd_pkg::CH_ZERO + d);
        if ($urandom_range(0, 1) == 0) return 8'(hcbd_pkg::CH_LA + d - 10);
        return 8'(hcbd_pkg::CH_UA + d - 10);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
    endtask

    task automatic put_ws();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: body_buf.push_back(hcbd_pkg::CH_SPACE);
                1: body_buf.push_back(hcbd_pkg::CH_TAB);
                2: body_buf.push_back(hcbd_pkg::CH_CR);
                3: body_buf.push_back(hcbd_pkg::CH_LF);
                4: body_buf.push_back(CH_VT);
                default: body_buf.push_back(CH_FF);
            endcase
        end
    endtask

    task automatic put_eol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            body_buf.push_back(hcbd_pkg::CH_CR);
            body_buf.push_back(hcbd_pkg::CH_LF);
        end else if (r < 8) begin
            body_buf.push_back(hcbd_pkg::CH_LF);
        end else if (r < 9) begin
            body_buf.push_back(hcbd_pkg::CH_CR);
        end else begin
            // chunk extension, taken as data
            body_buf.push_back(CH_SEMI);
        end
    endtask

    task automatic put_size_line(int unsigned v);
        int nd;
        put_ws();
        if ($urandom_range(0, 9) == 0) body_buf.push_back(hcbd_pkg::CH_PLUS);
        if ($urandom_range(0, 6) == 0) begin
            body_buf.push_back(hcbd_pkg::CH_ZERO);
            body_buf.push_back($urandom_range(0, 1) ? hcbd_pkg::CH_LX : hcbd_pkg::CH_UX);
        end else if ($urandom_range(0, 9) == 0) begin
            body_buf.push_back(hcbd_pkg::CH_ZERO);
        end
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
        for (int i = nd - 1; i >= 0; i--) body_buf.push_back(hex_char((v >> (4 * i)) & 15));
        put_eol();
    endtask

    task automatic flush_body(int cut);
        byte_beat_t b;
        for (int i = 0; i < cut; i++) begin
            b.data = body_buf[i];
            b.last = (i == cut - 1);
            byte_q.push_back(b);
        end
        body_buf.delete();
    endtask

    task automatic gen_body();
        int kind;
        int n;
        int sz;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
                put_size_line(sz);
                repeat (sz) body_buf.push_back(rand_byte());
                body_buf.push_back(hcbd_pkg::CH_CR);
                body_buf.push_back(hcbd_pkg::CH_LF);
            end
            put_ws();
            body_buf.push_back(hcbd_pkg::CH_ZERO);
            case ($urandom_range(0, 3))
                0: begin
                    body_buf.push_back(hcbd_pkg::CH_CR);
                    body_buf.push_back(hcbd_pkg::CH_LF);
                    body_buf.push_back(hcbd_pkg::CH_CR);
                    body_buf.push_back(hcbd_pkg::CH_LF);
                end
                1: put_str(";ext=1");
                2: repeat ($urandom_range(1, 4)) body_buf.push_back(rand_byte());
                default: ;
            endcase
            cut = body_buf.size();
            if ($urandom_range(0, 4) == 0) cut = $urandom_range(1, body_buf.size());
        end else if (kind < 80) begin
            // size wider than the counter
            put_ws();
            if ($urandom_range(0, 1) == 0) begin
                put_str("FFFFFFFF");
                body_buf.push_back(hex_char($urandom_range(0, 15)));
            end else begin
                body_buf.push_back(hex_char($urandom_range(1, 15)));
                repeat ($urandom_range(8, 11)) body_buf.push_back(hex_char($urandom_range(0, 15)));
            end
            body_buf.push_back(hcbd_pkg::CH_CR);
            body_buf.push_back(hcbd_pkg::CH_LF);
            repeat ($urandom_range(0, 10)) body_buf.push_back(rand_byte());
            cut = body_buf.size();
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 20)) body_buf.push_back(rand_byte());
            cut = body_buf.size();
        end else begin
            put_ws();
            case ($urandom_range(0, 5))
                0: put_str("-5");
                1: put_str("++3");
                2: put_str("0x;");
                3: put_str("00");
                4: put_str("+-1");
                default: put_str("0X");
            endcase
            body_buf.push_back(hcbd_pkg::CH_CR);
            body_buf.push_back(hcbd_pkg::CH_LF);
            repeat ($urandom_range(0, 4)) body_buf.push_back(rand_byte());
            cut = body_buf.size();
        end
        flush_body(cut);
    endtask

    // sender
    int         tx_gap  = 0;
    int         tx_run  = 0;
    bit         tx_calm = 1'b0;
    byte_beat_t tx_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                tx_beat = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tx_beat.data;
                s_tlast  <= tx_beat.last;
                if (tx_run == 0) begin
                    tx_run  = $urandom_range(20, 100);
                    tx_calm = ($urandom_range(0, 3) == 0);
                end
                tx_run = tx_run - 1;
                tx_gap = tx_calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with two long hold-offs so the input backs up
    int rx_cyc  = 0;
    int rx_gap  = 0;
    int rx_run  = 0;
    bit rx_calm = 1'b0;

    always @(posedge aclk) begin
        rx_cyc = rx_cyc + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if ((rx_cyc >= HOLD_A && rx_cyc < HOLD_A + HOLD_LEN) ||
                     (rx_cyc >= HOLD_B && rx_cyc < HOLD_B + HOLD_LEN)) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_run == 0) begin
                rx_run  = $urandom_range(30, 150);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            rx_run = rx_run - 1;
            rx_gap = rx_calm ? 0 : pick_gap();
        end
    end

    // predictor and checker
    hcbd_pkg::res_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected output beat: tdata %0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[7:0] !== want.out_byte) begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.out_byte, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tuser !== want.is_data) begin
                        $error("is_data mismatch: expected %0b, actual %0b",
                               want.is_data, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.end_of_body) begin
                        $error("end_of_body mismatch: expected %0b, actual %0b",
                               want.end_of_body, m_tlast);
                        errors++;
                    end
                    if (m_tdata[39:8] !== want.decoded_length) begin
                        $error("decoded_length mismatch: expected %0d, actual %0d",
                               want.decoded_length, m_tdata[39:8]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        // directed: prefix, sign, whitespace, an all-ones data byte
        put_str(" ");
        body_buf.push_back(hcbd_pkg::CH_TAB);
        put_str("+0x1");
        body_buf.push_back(hcbd_pkg::CH_CR);
        body_buf.push_back(hcbd_pkg::CH_LF);
        body_buf.push_back(8'hff);
        body_buf.push_back(hcbd_pkg::CH_CR);
        body_buf.push_back(hcbd_pkg::CH_LF);
        body_buf.push_back(hcbd_pkg::CH_ZERO);
        body_buf.push_back(hcbd_pkg::CH_CR);
        body_buf.push_back(hcbd_pkg::CH_LF);
        flush_body(body_buf.size());
        // bare prefix
        body_buf.push_back(hcbd_pkg::CH_ZERO);
        body_buf.push_back(hcbd_pkg::CH_UX);
        body_buf.push_back(CH_UG);
        flush_body(body_buf.size());
        // second sign
        put_str("++");
        body_buf.push_back(8'h00);
        flush_body(body_buf.size());
        // minus sign
        body_buf.push_back(CH_MINUS);
        flush_body(body_buf.size());
        // extension as data, final byte carrying data
        put_str("2;");
        body_buf.push_back(8'h00);
        flush_body(body_buf.size());
        // all-zero size
        put_str("00");
        body_buf.push_back(hcbd_pkg::CH_LF);
        flush_body(body_buf.size());
        // truncated chunk
        put_str("3a");
        body_buf.push_back(hcbd_pkg::CH_LF);
        body_buf.push_back(8'h80);
        flush_body(body_buf.size());

        n_directed = byte_q.size();
        while (byte_q.size() < n_directed + RAND_ITEMS) gen_body();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        while (byte_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
